@@ rtl/cba_pkg.sv @@
// Shared types and constants for the channel block averager.
package cba_pkg;

  // Number of channels held in the accumulator memory.
  localparam int CHANNELS = 64;
  localparam int CH_W     = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;

  // Field and accumulator widths.
  localparam int CHAN_W  = 6;
  localparam int TIME_W  = 32;
  localparam int VALUE_W = 32;
  localparam int SUM_W   = 42;
  localparam int COUNT_W = 11;
  localparam int BLEN_W  = 10;
  localparam int STEP_W  = $clog2(SUM_W + 1);

  localparam logic [BLEN_W-1:0] BLEN_RESET = BLEN_W'(1);

  // One incoming sample request.
  typedef struct packed {
    logic        [CHAN_W-1:0]  channel;
    logic        [TIME_W-1:0]  sample_time;
    logic signed [VALUE_W-1:0] sample_value;
  } in_item_t;

  // One block average result.
  typedef struct packed {
    logic        [CHAN_W-1:0]  out_channel;
    logic        [TIME_W-1:0]  mean_time;
    logic signed [VALUE_W-1:0] mean_value;
    logic        [COUNT_W-1:0] sample_count;
  } out_item_t;

  // One channel's accumulator entry.
  typedef struct packed {
    logic        [SUM_W-1:0]   time_sum;
    logic signed [SUM_W-1:0]   value_sum;
    logic        [COUNT_W-1:0] count;
  } entry_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic capture;
    logic update;
    logic div_start;
    logic out_load;
  } cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic report;
    logic div_done;
    logic out_free;
  } status_t;

endpackage

@@ rtl/cba_div.sv @@
// Restoring unsigned divider of a block sum by a sample count, one bit per cycle.
module cba_div
  import cba_pkg::*;
(
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  input  logic [SUM_W-1:0]   dividend,
  input  logic [COUNT_W-1:0] divisor,
  output logic               busy,
  output logic [SUM_W-1:0]   quotient
);

  logic [SUM_W-1:0]   work;
  logic [COUNT_W-1:0] rem;
  logic [COUNT_W-1:0] dvsr;
  logic [STEP_W-1:0]  steps;

  logic [COUNT_W:0]   shifted;
  logic [COUNT_W:0]   diff;
  logic               ge;

  // One trial subtraction per cycle.
  always_comb begin
    shifted = {rem, work[SUM_W-1]};
    diff    = shifted - {1'b0, dvsr};
    ge      = shifted >= {1'b0, dvsr};
  end

  // Step control.
  always_ff @(posedge clk) begin
    if (rst) begin
      busy  <= 1'b0;
      steps <= '0;
    end else if (start) begin
      busy  <= 1'b1;
      steps <= STEP_W'(SUM_W);
    end else if (busy) begin
      steps <= steps - STEP_W'(1);
      if (steps == STEP_W'(1)) begin
        busy <= 1'b0;
      end
    end
  end

  // Remainder and quotient shift register.
  always_ff @(posedge clk) begin
    if (start) begin
      work <= dividend;
      rem  <= '0;
      dvsr <= divisor;
    end else if (busy) begin
      work <= {work[SUM_W-2:0], ge};
      rem  <= ge ? diff[COUNT_W-1:0] : shifted[COUNT_W-1:0];
    end
  end

  assign quotient = work;

endmodule

@@ rtl/cba_ctrl.sv @@
// Controller state machine that sequences one sample request at a time.
module cba_ctrl
  import cba_pkg::*;
(
  input  logic    clk,
  input  logic    rst,
  input  logic    in_valid,
  output logic    in_ready,
  input  status_t status,
  output cmd_t    cmd
);

  typedef enum logic [3:0] {
    ST_IDLE   = 4'b0001,
    ST_DECIDE = 4'b0010,
    ST_DIVIDE = 4'b0100,
    ST_LOAD   = 4'b1000
  } state_t;

  state_t state;
  state_t state_next;

  // Next state and command decode.
  always_comb begin
    state_next = state;
    cmd        = '0;
    in_ready   = 1'b0;
    case (state)
      ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.capture = 1'b1;
          state_next  = ST_DECIDE;
        end
      end
      ST_DECIDE: begin
        cmd.update = 1'b1;
        if (status.report) begin
          cmd.div_start = 1'b1;
          state_next    = ST_DIVIDE;
        end else begin
          state_next = ST_IDLE;
        end
      end
      ST_DIVIDE: begin
        if (status.div_done) begin
          state_next = ST_LOAD;
        end
      end
      ST_LOAD: begin
        if (status.out_free) begin
          cmd.out_load = 1'b1;
          state_next   = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  // State register.
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

endmodule

@@ rtl/cba_datapath.sv @@
// Datapath: accumulator memory, sum update, two dividers and the result register.
module cba_datapath
  import cba_pkg::*;
(
  input  logic              clk,
  input  logic              rst,
  input  in_item_t          in_data,
  input  logic              cfg_valid,
  input  logic [BLEN_W-1:0] cfg_data,
  input  logic              out_ready,
  input  cmd_t              cmd,
  output status_t           status,
  output logic              out_valid,
  output out_item_t         out_data
);

  logic [BLEN_W-1:0]  block_length;
  in_item_t           item;
  entry_t             mem [CHANNELS];
  logic               filled [CHANNELS];
  entry_t             rd_entry;
  logic               rd_hit;

  entry_t             entry_cur;
  entry_t             wr_entry;
  logic               ch_ok;
  logic               accumulate;
  logic               wr_en;
  logic [CH_W-1:0]    wr_idx;
  logic [SUM_W-1:0]   value_abs;

  logic [CHAN_W-1:0]  res_ch;
  logic [COUNT_W-1:0] res_cnt;
  logic               res_neg;

  logic               busy_t;
  logic               busy_v;
  logic [SUM_W-1:0]   quot_t;
  logic [SUM_W-1:0]   quot_v;

  // Configuration register.
  always_ff @(posedge clk) begin
    if (rst) begin
      block_length <= BLEN_RESET;
    end else if (cfg_valid) begin
      block_length <= cfg_data;
    end
  end

  // Capture the request and read its channel entry.
  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      item     <= in_data;
      rd_entry <= mem[CH_W'(in_data.channel)];
      rd_hit   <= filled[CH_W'(in_data.channel)];
    end
  end

  // Decide between adding the sample and closing the block.
  always_comb begin
    entry_cur  = rd_hit ? rd_entry : '0;
    ch_ok      = 32'(item.channel) < CHANNELS;
    accumulate = entry_cur.count < {1'b0, block_length};
    wr_idx     = CH_W'(item.channel);
    wr_en      = cmd.update && ch_ok;
    if (accumulate) begin
      wr_entry.time_sum  = entry_cur.time_sum + SUM_W'(item.sample_time);
      wr_entry.value_sum = entry_cur.value_sum + SUM_W'(item.sample_value);
      wr_entry.count     = entry_cur.count + COUNT_W'(1);
    end else begin
      wr_entry.time_sum  = SUM_W'(item.sample_time);
      wr_entry.value_sum = SUM_W'(item.sample_value);
      wr_entry.count     = COUNT_W'(1);
    end
    value_abs = entry_cur.value_sum[SUM_W-1] ? SUM_W'(-entry_cur.value_sum)
                                             : entry_cur.value_sum;
    status.report   = ch_ok && !accumulate && (entry_cur.count != '0);
    status.div_done = !busy_t && !busy_v;
    status.out_free = !out_valid || out_ready;
  end

  // Accumulator memory write.
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_idx] <= wr_entry;
    end
  end

  // Written marks; an unwritten entry reads as zero.
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < CHANNELS; i++) begin
        filled[i] <= 1'b0;
      end
    end else if (wr_en) begin
      filled[wr_idx] <= 1'b1;
    end
  end

  // Result side information held during the division.
  always_ff @(posedge clk) begin
    if (cmd.div_start) begin
      res_ch  <= item.channel;
      res_cnt <= entry_cur.count;
      res_neg <= entry_cur.value_sum[SUM_W-1];
    end
  end

  // Mean time and mean magnitude dividers run side by side.
  cba_div u_div_time (
    .clk      (clk),
    .rst      (rst),
    .start    (cmd.div_start),
    .dividend (entry_cur.time_sum),
    .divisor  (entry_cur.count),
    .busy     (busy_t),
    .quotient (quot_t)
  );

  cba_div u_div_value (
    .clk      (clk),
    .rst      (rst),
    .start    (cmd.div_start),
    .dividend (value_abs),
    .divisor  (entry_cur.count),
    .busy     (busy_v),
    .quotient (quot_v)
  );

  // Result register and its valid flag.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.out_load) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      out_data.out_channel  <= res_ch;
      out_data.mean_time    <= quot_t[TIME_W-1:0];
      out_data.mean_value   <= res_neg ? -quot_v[VALUE_W-1:0] : quot_v[VALUE_W-1:0];
      out_data.sample_count <= res_cnt;
    end
  end

endmodule

@@ rtl/channel_block_averager.sv @@
// Top level of the per-channel block averager.
// Each sample request is added to its channel's running sums of time and value;
// once the channel holds block_length samples, the next sample closes the block,
// a result with the truncated mean time and mean value is produced, and the
// channel restarts with that sample. One request is handled at a time: a sample
// that only accumulates is captured and then updated, and one that closes a block
// is also divided by the two 42-bit bit-serial dividers running in parallel;
// once both finish, the result is loaded, after any wait for a previous result
// still held in the output register.
// New requests are taken while a finished result waits to be read.
// The block_length register may be written at any time the block is idle and
// resets to 1; the accumulators of all channels read as zero after reset.
module channel_block_averager
  import cba_pkg::*;
(
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_ready,
  input  in_item_t          in_data,
  output logic              out_valid,
  input  logic              out_ready,
  output out_item_t         out_data,
  input  logic              cfg_valid,
  output logic              cfg_ready,
  input  logic [BLEN_W-1:0] cfg_data
);

  cmd_t    cmd;
  status_t status;

  // The configuration register takes a write in any cycle.
  assign cfg_ready = 1'b1;

  cba_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .status   (status),
    .cmd      (cmd)
  );

  cba_datapath u_datapath (
    .clk       (clk),
    .rst       (rst),
    .in_data   (in_data),
    .cfg_valid (cfg_valid),
    .cfg_data  (cfg_data),
    .out_ready (out_ready),
    .cmd       (cmd),
    .status    (status),
    .out_valid (out_valid),
    .out_data  (out_data)
  );

  // One request is in flight at a time.
  assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready |=> !in_ready)
    else $error("request accepted while another is in flight");

  // A division starts only for a block that is reported.
  assert property (@(posedge clk) disable iff (rst)
    cmd.div_start |-> status.report)
    else $error("division started without a report");

  // A result is never loaded over one that is still waiting.
  assert property (@(posedge clk) disable iff (rst)
    cmd.out_load |-> status.out_free)
    else $error("pending result overwritten");

  // A new result appears only after a load command.
  assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(cmd.out_load))
    else $error("result valid without a load");

endmodule

@@ test/channel_block_averager_test.sv @@
// Self-checking testbench for the per-channel block averager.
`timescale 1ns / 1ps

module channel_block_averager_test;
  import cba_pkg::*;

  localparam int DRAIN_CYCLES = 60;

  // How a directed row is checked.
  typedef enum logic [1:0] {
    ROW_CFG,
    ROW_NONE,
    ROW_TYPED,
    ROW_PREDICT
  } row_kind_t;

  typedef enum logic [1:0] {
    IDLE_NONE,
    IDLE_SEND,
    IDLE_RECV,
    IDLE_BOTH
  } idle_mode_t;

  typedef struct packed {
    row_kind_t         kind;
    logic [BLEN_W-1:0] blen;
    in_item_t          smp;
    out_item_t         avg;
  } dir_row_t;

  typedef struct packed {
    logic [BLEN_W-1:0] blen;
    logic [11:0]       items;
    idle_mode_t        mode;
    logic              one_channel;
  } phase_t;

  localparam int DIR_ROWS = 23;
  localparam dir_row_t DIRECTED [DIR_ROWS] = '{
    // Reset block length of one: every sample after a channel's first reports.
    '{ROW_NONE,    10'd0, '{6'd0, 32'd0, 32'h00000000}, '0},
    '{ROW_TYPED,   10'd0, '{6'd0, 32'd100, 32'h00010000},
      '{6'd0, 32'd0, 32'h00000000, 11'd1}},
    '{ROW_NONE,    10'd0, '{6'd63, 32'hFFFFFFFF, 32'h80000000}, '0},
    '{ROW_TYPED,   10'd0, '{6'd63, 32'hFFFFFFFF, 32'h7FFFFFFF},
      '{6'd63, 32'hFFFFFFFF, 32'h80000000, 11'd1}},
    '{ROW_TYPED,   10'd0, '{6'd63, 32'd0, 32'h00000000},
      '{6'd63, 32'hFFFFFFFF, 32'h7FFFFFFF, 11'd1}},
    '{ROW_TYPED,   10'd0, '{6'd0, 32'd5, 32'hFFFFFFFF},
      '{6'd0, 32'd100, 32'h00010000, 11'd1}},
    // Block length zero: an empty channel only starts, later samples replace.
    '{ROW_CFG,     10'd0, '0, '0},
    '{ROW_NONE,    10'd0, '{6'd5, 32'd7, 32'h00000003}, '0},
    '{ROW_TYPED,   10'd0, '{6'd5, 32'd9, 32'hFFFFFFFD},
      '{6'd5, 32'd7, 32'h00000003, 11'd1}},
    '{ROW_TYPED,   10'd0, '{6'd0, 32'd1, 32'h00000001},
      '{6'd0, 32'd5, 32'hFFFFFFFF, 11'd1}},
    // Longest block, then the length is lowered below the stored count.
    '{ROW_CFG,     10'd1023, '0, '0},
    '{ROW_NONE,    10'd0, '{6'd1, 32'hFFFFFFFF, 32'h80000000}, '0},
    '{ROW_NONE,    10'd0, '{6'd1, 32'hFFFFFFFF, 32'h80000000}, '0},
    '{ROW_NONE,    10'd0, '{6'd1, 32'd3, 32'h80000001}, '0},
    '{ROW_NONE,    10'd0, '{6'd1, 32'hAAAAAAAA, 32'h55555555}, '0},
    '{ROW_CFG,     10'd2, '0, '0},
    '{ROW_PREDICT, 10'd0, '{6'd1, 32'd0, 32'h00000000}, '0},
    // Negative mean truncates toward zero.
    '{ROW_PREDICT, 10'd0, '{6'd2, 32'd10, 32'hFFFFFFFD}, '0},
    '{ROW_PREDICT, 10'd0, '{6'd2, 32'd11, 32'h00000000}, '0},
    '{ROW_PREDICT, 10'd0, '{6'd2, 32'd12, 32'h00000007}, '0},
    '{ROW_PREDICT, 10'd0, '{6'd1, 32'd2, 32'h00000002}, '0},
    '{ROW_PREDICT, 10'd0, '{6'd1, 32'd6, 32'hFFFFFFFB}, '0},
    '{ROW_PREDICT, 10'd0, '{6'd1, 32'd4, 32'h00000001}, '0}
  };

  localparam int PHASES = 7;
  localparam phase_t RANDOM_PHASES [PHASES] = '{
    '{10'd1,    12'd133,  IDLE_NONE, 1'b0},
    '{10'd0,    12'd133,  IDLE_SEND, 1'b0},
    '{10'd3,    12'd133,  IDLE_RECV, 1'b0},
    '{10'd1023, 12'd1030, IDLE_NONE, 1'b1},
    '{10'd5,    12'd133,  IDLE_BOTH, 1'b0},
    '{10'd2,    12'd133,  IDLE_RECV, 1'b0},
    '{10'd8,    12'd133,  IDLE_SEND, 1'b0}
  };

  logic              clk;
  logic              rst       = 1'b1;
  logic              in_valid  = 1'b0;
  logic              in_ready;
  in_item_t          in_data   = '0;
  logic              out_valid;
  logic              out_ready = 1'b0;
  out_item_t         out_data;
  logic              cfg_valid = 1'b0;
  logic              cfg_ready;
  logic [BLEN_W-1:0] cfg_data  = '0;

  // Running sums of each channel as the block should hold them.
  logic [SUM_W-1:0]  acc_time  [CHANNELS];
  longint            acc_value [CHANNELS];
  int unsigned       acc_count [CHANNELS];
  logic [BLEN_W-1:0] cur_block_length;

  out_item_t   expected_averages [$];
  int unsigned idle_pct         = 0;
  int unsigned stall_pct        = 0;
  int unsigned errors           = 0;
  int unsigned samples_sent     = 0;
  int unsigned averages_checked = 0;
  int unsigned settings_written = 0;

  channel_block_averager dut (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_data  (cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    #10_000_000;
    $display("channel_block_averager_test NOT OK");
    $finish;
  end

  // Adds a sample to its channel, or closes the block and restarts it.
  // Returns whether a block average comes out.
  function automatic bit average_sample(input in_item_t s, output out_item_t avg);
    int unsigned ch;
    longint      v;
    bit          has;
    ch  = s.channel;
    v   = longint'($signed(s.sample_value));
    avg = '0;
    has = 1'b0;
    if (ch < CHANNELS) begin
      if (acc_count[ch] < cur_block_length) begin
        acc_time[ch]  = acc_time[ch] + s.sample_time;
        acc_value[ch] = acc_value[ch] + v;
        acc_count[ch] = acc_count[ch] + 1;
      end else begin
        if (acc_count[ch] != 0) begin
          has              = 1'b1;
          avg.out_channel  = s.channel;
          avg.mean_time    = TIME_W'(acc_time[ch] / SUM_W'(acc_count[ch]));
          avg.mean_value   = VALUE_W'(acc_value[ch] / longint'(acc_count[ch]));
          avg.sample_count = COUNT_W'(acc_count[ch]);
        end
        acc_time[ch]  = SUM_W'(s.sample_time);
        acc_value[ch] = v;
        acc_count[ch] = 1;
      end
    end
    return has;
  endfunction

  // Field values biased toward the extremes.
  function automatic logic [31:0] pick_word();
    case ($urandom_range(9))
      0: return 32'h00000000;
      1: return 32'hFFFFFFFF;
      2: return 32'h80000000;
      3: return 32'h7FFFFFFF;
      default: return $urandom;
    endcase
  endfunction

  // Offers one sample request; returns at the edge where it is taken.
  // Valid stays high so the next request can follow back to back.
  task automatic push_sample(input in_item_t s, input bit typed, input bit typed_has,
                             input out_item_t typed_avg);
    out_item_t avg;
    bit        has;
    in_data  <= s;
    in_valid <= 1'b1;
    do @(posedge clk); while (!in_ready);
    has = average_sample(s, avg);
    if (typed) begin
      has = typed_has;
      avg = typed_avg;
    end
    if (has) expected_averages.push_back(avg);
    samples_sent++;
  endtask

  // Waits until every average is out and the last sample has settled.
  task automatic wait_drained();
    in_valid <= 1'b0;
    while (expected_averages.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic write_block_length(input logic [BLEN_W-1:0] blen);
    wait_drained();
    cfg_data  <= blen;
    cfg_valid <= 1'b1;
    do @(posedge clk); while (!cfg_ready);
    cur_block_length = blen;
    settings_written++;
    cfg_valid <= 1'b0;
  endtask

  // Receiver side: random back-pressure at the rate of the current phase.
  always @(posedge clk) begin
    out_ready <= ($urandom_range(99) >= stall_pct);
  end

  // Compare each average that leaves the block with the oldest expectation.
  always @(posedge clk) begin
    out_item_t want;
    if (!rst && out_valid && out_ready) begin
      if (expected_averages.size() == 0) begin
        $error("unexpected average on channel %0d", out_data.out_channel);
        errors++;
      end else begin
        want = expected_averages.pop_front();
        averages_checked++;
        if (out_data.out_channel !== want.out_channel) begin
          $error("out_channel: expected %0d, got %0d", want.out_channel,
                 out_data.out_channel);
          errors++;
        end
        if (out_data.mean_time !== want.mean_time) begin
          $error("mean_time: expected %0d, got %0d", want.mean_time, out_data.mean_time);
          errors++;
        end
        if (out_data.mean_value !== want.mean_value) begin
          $error("mean_value: expected %0d, got %0d", $signed(want.mean_value),
                 $signed(out_data.mean_value));
          errors++;
        end
        if (out_data.sample_count !== want.sample_count) begin
          $error("sample_count: expected %0d, got %0d", want.sample_count,
                 out_data.sample_count);
          errors++;
        end
      end
    end
  end

  initial begin
    in_item_t    s;
    int unsigned fixed_ch;
    for (int c = 0; c < CHANNELS; c++) begin
      acc_time[c]  = '0;
      acc_value[c] = 0;
      acc_count[c] = 0;
    end
    cur_block_length = BLEN_RESET;

    repeat (7) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed part, no idling on either side.
    for (int r = 0; r < DIR_ROWS; r++) begin
      if (DIRECTED[r].kind == ROW_CFG) begin
        write_block_length(DIRECTED[r].blen);
      end else begin
        push_sample(DIRECTED[r].smp, DIRECTED[r].kind != ROW_PREDICT,
                    DIRECTED[r].kind == ROW_TYPED, DIRECTED[r].avg);
      end
    end

    // Random phases, each with its own block length and idling pattern.
    for (int p = 0; p < PHASES; p++) begin
      write_block_length(RANDOM_PHASES[p].blen);
      case (RANDOM_PHASES[p].mode)
        IDLE_NONE: begin idle_pct = 0;  stall_pct = 0;  end
        IDLE_SEND: begin idle_pct = 87; stall_pct = 0;  end
        IDLE_RECV: begin idle_pct = 0;  stall_pct = 87; end
        default:   begin idle_pct = 9;  stall_pct = 9;  end
      endcase
      fixed_ch = $urandom_range(CHANNELS - 1);
      for (int i = 0; i < RANDOM_PHASES[p].items; i++) begin
        while ($urandom_range(99) < idle_pct) begin
          in_valid <= 1'b0;
          @(posedge clk);
        end
        // Mostly a few busy channels so blocks close often.
        if (RANDOM_PHASES[p].one_channel) s.channel = CHAN_W'(fixed_ch);
        else if ($urandom_range(9) < 7) s.channel = CHAN_W'($urandom_range(3));
        else s.channel = CHAN_W'($urandom_range(CHANNELS - 1));
        s.sample_time  = pick_word();
        s.sample_value = pick_word();
        push_sample(s, 1'b0, 1'b0, '0);
      end
    end

    idle_pct  = 0;
    stall_pct = 0;
    wait_drained();
    $display("Sent %0d samples over %0d block length settings.", samples_sent,
             settings_written);
    $display("Checked %0d block averages.", averages_checked);
    if (errors == 0) begin
      $display("channel_block_averager_test OK");
    end else begin
      $display("channel_block_averager_test NOT OK");
    end
    $finish;
  end

endmodule
